[rtl/kea_pkg.sv]
// shared types, constants and helpers for the key event queue with autorepeat
// used by kea_repeat, the top module and the testbench; no dependencies

package kea_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int TEXT_BYTES  = 8;
	localparam int AW          = $clog2(QUEUE_DEPTH);
	localparam int CW          = $clog2(QUEUE_DEPTH + 1);

	// field widths
	localparam int TEXT_W = 64;
	localparam int KEY_W  = 8;
	localparam int MOD_W  = 8;
	localparam int CNT_W  = 16;

	// configuration port
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 16;
	localparam logic [CFG_AW-1:0] REG_DELAY     = 2'd0;
	localparam logic [CFG_AW-1:0] REG_INTERVAL  = 2'd1;
	localparam logic [CFG_AW-1:0] REG_MOD_FIRST = 2'd2;
	localparam logic [CFG_AW-1:0] REG_MOD_LAST  = 2'd3;

	// reset values of the registers
	localparam logic [CNT_W-1:0] DELAY_RST     = 16'd500;
	localparam logic [CNT_W-1:0] INTERVAL_RST  = 16'd50;
	localparam logic [KEY_W-1:0] MOD_FIRST_RST = 8'd224;
	localparam logic [KEY_W-1:0] MOD_LAST_RST  = 8'd231;

	// no key held
	localparam logic [KEY_W-1:0] KEY_NONE = 8'd0;

	typedef enum logic [1:0] {
		REQ_SUBMIT = 2'd0,
		REQ_TICK   = 2'd1,
		REQ_POP    = 2'd2
	} req_e;

	typedef enum logic [1:0] {
		KIND_DOWN  = 2'd0,
		KIND_UP    = 2'd1,
		KIND_TEXT  = 2'd2,
		KIND_OTHER = 2'd3
	} kind_e;

	typedef struct packed {
		logic [CNT_W-1:0] delay;
		logic [CNT_W-1:0] interval;
		logic [KEY_W-1:0] mod_first;
		logic [KEY_W-1:0] mod_last;
	} cfg_t;

	// one queue entry as stored in memory
	typedef struct packed {
		logic              rep;
		logic [MOD_W-1:0]  mods;
		logic [KEY_W-1:0]  key;
		kind_e             kind;
		logic [TEXT_W-1:0] text;
	} entry_t;

	// command to the held-key tracker
	typedef struct packed {
		logic              submit;
		logic              tick;
		kind_e             kind;
		logic [KEY_W-1:0]  key;
		logic [MOD_W-1:0]  mods;
		logic [TEXT_W-1:0] text;
	} rpt_cmd_t;

	// held-key status back to the controller
	typedef struct packed {
		logic              fire;
		logic [KEY_W-1:0]  code;
		logic [MOD_W-1:0]  mods;
		logic [TEXT_W-1:0] chars;
		logic [MOD_W-1:0]  char_mods;
	} rpt_state_t;

	// one result beat
	typedef struct packed {
		logic              valid;
		kind_e             kind;
		logic [KEY_W-1:0]  key;
		logic [MOD_W-1:0]  mods;
		logic              rep;
		logic [TEXT_W-1:0] text;
		logic [CW-1:0]     level;
	} res_t;

	// keep bytes up to the first zero byte, at most TEXT_BYTES of them
	function automatic logic [TEXT_W-1:0] clean_text(input logic [TEXT_W-1:0] t);
		logic [TEXT_W-1:0] r;
		logic live;
		r = '0;
		live = 1'b1;
		for (int i = 0; i < TEXT_W / 8; i++) begin
			if (t[8*i +: 8] == 8'h00)
				live = 1'b0;
			if (live && (i < TEXT_BYTES))
				r[8*i +: 8] = t[8*i +: 8];
		end
		return r;
	endfunction

endpackage

[rtl/kea_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module kea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[rtl/kea_repeat.sv]
// held-key tracker: held key, held text and the typematic countdown
// depends on kea_pkg

module kea_repeat (
	input  logic                clk,
	input  logic                arst_n,
	input  kea_pkg::cfg_t       cfg,
	input  kea_pkg::rpt_cmd_t   cmd,
	output kea_pkg::rpt_state_t st
);

	logic [kea_pkg::KEY_W-1:0]  code_q;
	logic [kea_pkg::MOD_W-1:0]  mods_q;
	logic [kea_pkg::TEXT_W-1:0] chars_q;
	logic [kea_pkg::MOD_W-1:0]  char_mods_q;
	logic [kea_pkg::CNT_W-1:0]  cd_q;

	logic                       is_mod;
	logic                       fire;
	logic [kea_pkg::CNT_W-1:0]  delay_min;
	logic [kea_pkg::CNT_W-1:0]  ival_min;

	// zero delay or interval counts as one
	assign delay_min = (cfg.delay == '0) ? kea_pkg::CNT_W'(1) : cfg.delay;
	assign ival_min  = (cfg.interval == '0) ? kea_pkg::CNT_W'(1) : cfg.interval;

	// modifier range check, empty when first is above last
	assign is_mod = (cmd.key >= cfg.mod_first) && (cmd.key <= cfg.mod_last);

	// countdown reaches zero on this tick
	assign fire = cmd.tick && (code_q != kea_pkg::KEY_NONE) &&
		(cd_q == kea_pkg::CNT_W'(1));

	assign st.fire      = fire;
	assign st.code      = code_q;
	assign st.mods      = mods_q;
	assign st.chars     = chars_q;
	assign st.char_mods = char_mods_q;

	// held state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q      <= '0;
			mods_q      <= '0;
			chars_q     <= '0;
			char_mods_q <= '0;
			cd_q        <= '0;
		end else if (cmd.submit) begin
			if (cmd.kind == kea_pkg::KIND_DOWN && !is_mod) begin
				code_q      <= cmd.key;
				mods_q      <= cmd.mods;
				chars_q     <= '0;
				char_mods_q <= '0;
				cd_q        <= delay_min;
			end else if (cmd.kind == kea_pkg::KIND_UP && cmd.key == code_q) begin
				code_q      <= '0;
				mods_q      <= '0;
				chars_q     <= '0;
				char_mods_q <= '0;
				cd_q        <= '0;
			end else if (cmd.kind == kea_pkg::KIND_TEXT && code_q != kea_pkg::KEY_NONE) begin
				chars_q     <= cmd.text;
				char_mods_q <= cmd.mods;
			end
		end else if (cmd.tick && code_q != kea_pkg::KEY_NONE && cd_q != '0) begin
			if (fire)
				cd_q <= ival_min;
			else
				cd_q <= cd_q - kea_pkg::CNT_W'(1);
		end
	end

	// a held key always has a running countdown
	a_held_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(code_q != kea_pkg::KEY_NONE) |-> (cd_q != '0))
		else $error("held key without countdown");

	// text is only held while a key is held
	a_text_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		(chars_q != '0) |-> (code_q != kea_pkg::KEY_NONE))
		else $error("held text without held key");

	// an expiry reloads with the interval
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (cd_q == $past(ival_min)))
		else $error("countdown not reloaded after repeat");

endmodule

[rtl/key_event_queue_autorepeat.sv]
// key event queue with typematic autorepeat: one item in flight at a time.
// a submit, a plain tick or an empty pop finishes in the execute state; a pop with data
// also passes the read state (queue memory read) and a repeat with held text the second
// push state (two writes to the queue memory). a new item is taken only once the last one
// is finished, and later while a finished result waits on a stalled receiver.
// reset clears queue pointers, held key and countdown, and loads default config.

module key_event_queue_autorepeat (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration writes
	input  logic                        cfg_we,
	input  logic [kea_pkg::CFG_AW-1:0]  cfg_index,
	input  logic [kea_pkg::CFG_DW-1:0]  cfg_data,
	// request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [1:0]                  ev_kind,
	input  logic [kea_pkg::KEY_W-1:0]   ev_key,
	input  logic [kea_pkg::MOD_W-1:0]   ev_modifiers,
	input  logic                        ev_repeat,
	input  logic [kea_pkg::TEXT_W-1:0]  ev_text,
	// result channel
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic                        out_valid,
	output logic [1:0]                  out_kind,
	output logic [kea_pkg::KEY_W-1:0]   out_key,
	output logic [kea_pkg::MOD_W-1:0]   out_modifiers,
	output logic                        out_repeat,
	output logic [kea_pkg::TEXT_W-1:0]  out_text,
	output logic [kea_pkg::CW-1:0]      queue_level
);

	localparam int AW = kea_pkg::AW;
	localparam int CW = kea_pkg::CW;
	localparam int EW = $bits(kea_pkg::entry_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PUSH2,
		S_POPRD,
		S_DONE
	} state_t;

	state_t                     state_q, state_d;
	kea_pkg::cfg_t              cfg_q;
	kea_pkg::req_e              req_q;
	kea_pkg::kind_e             kind_q;
	logic [kea_pkg::KEY_W-1:0]  key_q;
	logic [kea_pkg::MOD_W-1:0]  mods_q;
	logic                       rep_q;
	logic [kea_pkg::TEXT_W-1:0] text_q;
	logic [AW-1:0]              head_q, head_d;
	logic [CW-1:0]              count_q, count_d;
	logic                       rsp_valid_q;
	kea_pkg::res_t              res_q, res_d, pend_q;

	kea_pkg::rpt_cmd_t          rpt_cmd;
	kea_pkg::rpt_state_t        rpt_st;

	logic                       push_en;
	kea_pkg::entry_t            push_ent;
	logic                       pop_rd;
	logic                       finish;
	logic                       out_free;
	logic [EW-1:0]              ram_rdata;
	kea_pkg::entry_t            rd_ent;

	logic                       full;
	logic [AW-1:0]              head_adj;
	logic [CW-1:0]              cnt_adj;
	logic [AW:0]                tail_sum;
	logic [AW-1:0]              tail;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == AW'(kea_pkg::QUEUE_DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !rsp_valid_q || rsp_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay     <= kea_pkg::DELAY_RST;
			cfg_q.interval  <= kea_pkg::INTERVAL_RST;
			cfg_q.mod_first <= kea_pkg::MOD_FIRST_RST;
			cfg_q.mod_last  <= kea_pkg::MOD_LAST_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				kea_pkg::REG_DELAY:     cfg_q.delay     <= cfg_data;
				kea_pkg::REG_INTERVAL:  cfg_q.interval  <= cfg_data;
				kea_pkg::REG_MOD_FIRST: cfg_q.mod_first <= cfg_data[kea_pkg::KEY_W-1:0];
				kea_pkg::REG_MOD_LAST:  cfg_q.mod_last  <= cfg_data[kea_pkg::KEY_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture on an accepted beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q  <= kea_pkg::req_e'(req_type);
			kind_q <= kea_pkg::kind_e'(ev_kind);
			key_q  <= ev_key;
			mods_q <= ev_modifiers;
			rep_q  <= ev_repeat;
			text_q <= kea_pkg::clean_text(ev_text);
		end
	end

	// held-key tracker commands
	always_comb begin
		rpt_cmd.submit = (state_q == S_EXEC) && (req_q == kea_pkg::REQ_SUBMIT) && !rep_q;
		rpt_cmd.tick   = (state_q == S_EXEC) && (req_q == kea_pkg::REQ_TICK);
		rpt_cmd.kind   = kind_q;
		rpt_cmd.key    = key_q;
		rpt_cmd.mods   = mods_q;
		rpt_cmd.text   = text_q;
	end

	kea_repeat u_repeat (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (rpt_cmd),
		.st     (rpt_st)
	);

	// push position: a full queue drops its oldest entry first
	always_comb begin
		full     = (count_q == CW'(kea_pkg::QUEUE_DEPTH));
		head_adj = full ? next_idx(head_q) : head_q;
		cnt_adj  = full ? CW'(kea_pkg::QUEUE_DEPTH - 1) : count_q;
		tail_sum = (AW+1)'(head_adj) + (AW+1)'(cnt_adj[AW-1:0]);
		tail     = (tail_sum >= (AW+1)'(kea_pkg::QUEUE_DEPTH)) ?
			AW'(tail_sum - (AW+1)'(kea_pkg::QUEUE_DEPTH)) : AW'(tail_sum);
	end

	assign rd_ent = kea_pkg::entry_t'(ram_rdata);

	kea_ram #(
		.WIDTH (EW),
		.DEPTH (kea_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push_en),
		.waddr (tail),
		.wdata (EW'(push_ent)),
		.re    (pop_rd),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	// sequencer next-state and queue updates
	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		push_en  = 1'b0;
		push_ent = '0;
		pop_rd   = 1'b0;
		finish   = 1'b0;
		res_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				case (req_q)
					kea_pkg::REQ_SUBMIT: begin
						if (!rep_q) begin
							push_en       = 1'b1;
							push_ent.kind = kind_q;
							push_ent.key  = key_q;
							push_ent.mods = mods_q;
							push_ent.text = text_q;
						end
						finish = 1'b1;
					end
					kea_pkg::REQ_TICK: begin
						if (rpt_st.fire) begin
							push_en       = 1'b1;
							push_ent.kind = kea_pkg::KIND_DOWN;
							push_ent.key  = rpt_st.code;
							push_ent.mods = rpt_st.mods;
							push_ent.rep  = 1'b1;
							if (rpt_st.chars != '0)
								state_d = S_PUSH2;
							else
								finish = 1'b1;
						end else begin
							finish = 1'b1;
						end
					end
					kea_pkg::REQ_POP: begin
						if (count_q != '0) begin
							pop_rd  = 1'b1;
							state_d = S_POPRD;
						end else begin
							finish = 1'b1;
						end
					end
					default: finish = 1'b1;
				endcase
			end
			S_PUSH2: begin
				// repeated text event follows the repeated key-down
				push_en       = 1'b1;
				push_ent.kind = kea_pkg::KIND_TEXT;
				push_ent.mods = rpt_st.char_mods;
				push_ent.rep  = 1'b1;
				push_ent.text = rpt_st.chars;
				finish        = 1'b1;
			end
			S_POPRD: begin
				res_d.valid = 1'b1;
				res_d.kind  = rd_ent.kind;
				res_d.key   = rd_ent.key;
				res_d.mods  = rd_ent.mods;
				res_d.rep   = rd_ent.rep;
				res_d.text  = rd_ent.text;
				head_d      = next_idx(head_q);
				count_d     = count_q - CW'(1);
				finish      = 1'b1;
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (push_en) begin
			head_d  = head_adj;
			count_d = cnt_adj + CW'(1);
		end
		res_d.level = count_d;
		if (finish)
			state_d = out_free ? S_IDLE : S_DONE;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// result parked while the output register is still occupied
	always_ff @(posedge clk) begin
		if (finish && !out_free)
			pend_q <= res_d;
	end

	// sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			state_q <= state_d;
			if (finish && out_free) begin
				rsp_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
				res_q       <= pend_q;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign out_valid     = res_q.valid;
	assign out_kind      = res_q.kind;
	assign out_key       = res_q.key;
	assign out_modifiers = res_q.mods;
	assign out_repeat    = res_q.rep;
	assign out_text      = res_q.text;
	assign queue_level   = res_q.level;

	// fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(kea_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");

	// a pop with data takes exactly one entry
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POPRD) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not remove one entry");

	// second push only straight after a repeating tick
	a_push2_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH2) |-> ($past(state_q) == S_EXEC))
		else $error("text repeat out of sequence");

	// a parked result only waits behind an occupied output register
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> rsp_valid_q)
		else $error("result parked with output register empty");

endmodule

[dv/kea_checker.sv]
// result checker for key_event_queue_autorepeat: follows the request, result and
// register ports, keeps its own copy of the queue and held-key state, compares beats
// depends on kea_pkg
`timescale 1ns / 100ps

module kea_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [kea_pkg::CFG_AW-1:0]  cfg_index,
	input  logic [kea_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [1:0]                  ev_kind,
	input  logic [kea_pkg::KEY_W-1:0]   ev_key,
	input  logic [kea_pkg::MOD_W-1:0]   ev_modifiers,
	input  logic                        ev_repeat,
	input  logic [kea_pkg::TEXT_W-1:0]  ev_text,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  logic                        out_valid,
	input  logic [1:0]                  out_kind,
	input  logic [kea_pkg::KEY_W-1:0]   out_key,
	input  logic [kea_pkg::MOD_W-1:0]   out_modifiers,
	input  logic                        out_repeat,
	input  logic [kea_pkg::TEXT_W-1:0]  out_text,
	input  logic [kea_pkg::CW-1:0]      queue_level,
	output int                          mismatch_count,
	output int                          results_owed
);

	localparam int QUEUE_DEPTH = kea_pkg::QUEUE_DEPTH;
	localparam int TEXT_BYTES  = kea_pkg::TEXT_BYTES;
	localparam int AW          = kea_pkg::AW;
	localparam int CW          = kea_pkg::CW;
	localparam int KEY_W       = kea_pkg::KEY_W;
	localparam int MOD_W       = kea_pkg::MOD_W;
	localparam int TEXT_W      = kea_pkg::TEXT_W;
	localparam int CNT_W       = kea_pkg::CNT_W;

	// model of the event queue
	kea_pkg::entry_t   ev_mem [QUEUE_DEPTH];
	logic [AW-1:0]     rd_ptr;
	int                fill;

	// model of the held key and its typematic countdown
	logic [KEY_W-1:0]  hold_code;
	logic [MOD_W-1:0]  hold_code_mods;
	logic [TEXT_W-1:0] hold_chars;
	logic [MOD_W-1:0]  hold_chars_mods;
	logic [CNT_W-1:0]  countdown;
	kea_pkg::cfg_t     cfg;

	// results still to come from the block, oldest first
	kea_pkg::res_t     owed_results [$];
	kea_pkg::res_t     want;

	initial mismatch_count = 0;

	task automatic flag(input string what, input logic [63:0] got,
		input logic [63:0] exp_val);
		$display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got,
			exp_val);
		mismatch_count++;
	endtask

	// text keeps the bytes before the first zero byte
	function automatic logic [TEXT_W-1:0] trim_text(input logic [TEXT_W-1:0] raw);
		logic [TEXT_W-1:0] kept;
		kept = '0;
		for (int i = 0; i < TEXT_BYTES && raw[8*i +: 8] != 8'h00; i++)
			kept[8*i +: 8] = raw[8*i +: 8];
		return kept;
	endfunction

	// a zero delay or interval counts as one tick
	function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
		return (v == '0) ? CNT_W'(1) : v;
	endfunction

	// append an entry; a full queue loses its oldest one
	function automatic void enqueue(input kea_pkg::kind_e k, input logic [KEY_W-1:0] key,
		input logic [MOD_W-1:0] mods, input logic rep, input logic [TEXT_W-1:0] text);
		kea_pkg::entry_t e;
		logic [AW-1:0] tail;
		if (fill >= QUEUE_DEPTH) begin
			rd_ptr = rd_ptr + AW'(1);
			fill = QUEUE_DEPTH - 1;
		end
		tail = rd_ptr + AW'(fill);
		e.kind = k;
		e.key = key;
		e.mods = mods;
		e.rep = rep;
		e.text = text;
		ev_mem[tail] = e;
		fill++;
	endfunction

	// advance the model by one request and return the result it owes
	function automatic kea_pkg::res_t step_queue(input logic [1:0] req,
		input logic [1:0] kind_raw, input logic [KEY_W-1:0] key,
		input logic [MOD_W-1:0] mods, input logic rep, input logic [TEXT_W-1:0] raw_text);
		kea_pkg::res_t r;
		kea_pkg::entry_t e;
		kea_pkg::kind_e kind;
		logic [TEXT_W-1:0] text;
		logic is_mod;
		r = '0;
		kind = kea_pkg::kind_e'(kind_raw);
		text = trim_text(raw_text);
		is_mod = (key >= cfg.mod_first) && (key <= cfg.mod_last);
		case (req)
			kea_pkg::REQ_SUBMIT: begin
				if (!rep) begin
					if (kind == kea_pkg::KIND_DOWN && !is_mod) begin
						hold_code = key;
						hold_code_mods = mods;
						hold_chars = '0;
						hold_chars_mods = '0;
						countdown = at_least_one(cfg.delay);
					end else if (kind == kea_pkg::KIND_UP && key == hold_code) begin
						hold_code = kea_pkg::KEY_NONE;
						hold_code_mods = '0;
						hold_chars = '0;
						hold_chars_mods = '0;
						countdown = '0;
					end else if (kind == kea_pkg::KIND_TEXT && hold_code != kea_pkg::KEY_NONE) begin
						hold_chars = text;
						hold_chars_mods = mods;
					end
					enqueue(kind, key, mods, 1'b0, text);
				end
			end
			kea_pkg::REQ_TICK: begin
				if (hold_code != kea_pkg::KEY_NONE && countdown != '0) begin
					countdown = countdown - CNT_W'(1);
					if (countdown == '0) begin
						countdown = at_least_one(cfg.interval);
						enqueue(kea_pkg::KIND_DOWN, hold_code, hold_code_mods, 1'b1, '0);
						if (hold_chars != '0)
							enqueue(kea_pkg::KIND_TEXT, kea_pkg::KEY_NONE, hold_chars_mods,
								1'b1, hold_chars);
					end
				end
			end
			kea_pkg::REQ_POP: begin
				if (fill != 0) begin
					e = ev_mem[rd_ptr];
					r.valid = 1'b1;
					r.kind = e.kind;
					r.key = e.key;
					r.mods = e.mods;
					r.rep = e.rep;
					r.text = e.text;
					rd_ptr = rd_ptr + AW'(1);
					fill--;
				end
			end
			default: ;
		endcase
		r.level = CW'(fill);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr = '0;
			fill = 0;
			hold_code = kea_pkg::KEY_NONE;
			hold_code_mods = '0;
			hold_chars = '0;
			hold_chars_mods = '0;
			countdown = '0;
			cfg.delay = kea_pkg::DELAY_RST;
			cfg.interval = kea_pkg::INTERVAL_RST;
			cfg.mod_first = kea_pkg::MOD_FIRST_RST;
			cfg.mod_last = kea_pkg::MOD_LAST_RST;
			owed_results.delete();
			results_owed <= 0;
		end else begin
			// result beat against the oldest owed result
			if (rsp_valid && rsp_ready) begin
				if (owed_results.size() == 0) begin
					flag("result beat with nothing owed", 64'(out_valid), 64'(0));
				end else begin
					want = owed_results.pop_front();
					if (out_valid !== want.valid)
						flag("out_valid", 64'(out_valid), 64'(want.valid));
					if (out_kind !== want.kind)
						flag("out_kind", 64'(out_kind), 64'(want.kind));
					if (out_key !== want.key)
						flag("out_key", 64'(out_key), 64'(want.key));
					if (out_modifiers !== want.mods)
						flag("out_modifiers", 64'(out_modifiers), 64'(want.mods));
					if (out_repeat !== want.rep)
						flag("out_repeat", 64'(out_repeat), 64'(want.rep));
					if (out_text !== want.text)
						flag("out_text", out_text, want.text);
					if (queue_level !== want.level)
						flag("queue_level", 64'(queue_level), 64'(want.level));
				end
			end
			// request beat
			if (in_valid && in_ready)
				owed_results.push_back(step_queue(req_type, ev_kind, ev_key, ev_modifiers,
					ev_repeat, ev_text));
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					kea_pkg::REG_DELAY:     cfg.delay = cfg_data;
					kea_pkg::REG_INTERVAL:  cfg.interval = cfg_data;
					kea_pkg::REG_MOD_FIRST: cfg.mod_first = cfg_data[KEY_W-1:0];
					kea_pkg::REG_MOD_LAST:  cfg.mod_last = cfg_data[KEY_W-1:0];
					default: ;
				endcase
			end
			results_owed <= owed_results.size();
		end
	end

endmodule

[dv/tb_top.sv]
// testbench top for key_event_queue_autorepeat: clock, reset, register phases,
// directed and random requests with random sender gaps and receiver stalls, verdict
// depends on kea_pkg, kea_checker and the block
`timescale 1ns / 100ps

module tb_top;

	localparam int CFG_AW = kea_pkg::CFG_AW;
	localparam int CFG_DW = kea_pkg::CFG_DW;
	localparam int KEY_W  = kea_pkg::KEY_W;
	localparam int MOD_W  = kea_pkg::MOD_W;
	localparam int TEXT_W = kea_pkg::TEXT_W;
	localparam int CNT_W  = kea_pkg::CNT_W;
	localparam int CW     = kea_pkg::CW;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 270;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_AW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          req_type;
	logic [1:0]          ev_kind;
	logic [KEY_W-1:0]    ev_key;
	logic [MOD_W-1:0]    ev_modifiers;
	logic                ev_repeat;
	logic [TEXT_W-1:0]   ev_text;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	logic                out_valid;
	logic [1:0]          out_kind;
	logic [KEY_W-1:0]    out_key;
	logic [MOD_W-1:0]    out_modifiers;
	logic                out_repeat;
	logic [TEXT_W-1:0]   out_text;
	logic [CW-1:0]       queue_level;

	int                  mismatch_count;
	int                  results_owed;
	int                  cycles = 0;
	int                  stall_left = 0;
	bit                  gaps_on = 1'b0;
	logic [KEY_W-1:0]    pressed_key;
	logic [KEY_W-1:0]    mod_lo;
	logic [KEY_W-1:0]    mod_hi;

	key_event_queue_autorepeat uut (.*);

	kea_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// random receiver stalls, started only while gaps are on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			rsp_ready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// one request beat, then maybe a sender gap
	task automatic send(input logic [1:0] req, input logic [1:0] kind,
		input logic [KEY_W-1:0] key, input logic [MOD_W-1:0] mods, input logic rep,
		input logic [TEXT_W-1:0] text);
		in_valid <= 1'b1;
		req_type <= req;
		ev_kind <= kind;
		ev_key <= key;
		ev_modifiers <= mods;
		ev_repeat <= rep;
		ev_text <= text;
		do @(posedge clk); while (!in_ready);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// let every owed result come back, then leave the block idle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all four registers; upper data bits of the byte registers are junk
	task automatic set_regs(input logic [CNT_W-1:0] delay, input logic [CNT_W-1:0] interval,
		input logic [KEY_W-1:0] first, input logic [KEY_W-1:0] last);
		cfg_we <= 1'b1;
		cfg_index <= kea_pkg::REG_DELAY;
		cfg_data <= delay;
		@(posedge clk);
		cfg_index <= kea_pkg::REG_INTERVAL;
		cfg_data <= interval;
		@(posedge clk);
		cfg_index <= kea_pkg::REG_MOD_FIRST;
		cfg_data <= {8'($urandom), first};
		@(posedge clk);
		cfg_index <= kea_pkg::REG_MOD_LAST;
		cfg_data <= {8'($urandom), last};
		@(posedge clk);
		cfg_we <= 1'b0;
		mod_lo = first;
		mod_hi = last;
	endtask

	// random text, sometimes cut by a zero byte or short
	function automatic logic [TEXT_W-1:0] rand_text();
		logic [TEXT_W-1:0] t;
		t = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: t[8*$urandom_range(0, 7) +: 8] = 8'h00;
			1: t = t >> (8 * $urandom_range(5, 7));
			default: ;
		endcase
		return t;
	endfunction

	// key code: mostly ordinary, sometimes a modifier or the unknown key
	function automatic logic [KEY_W-1:0] rand_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 9))
			0: k = (mod_lo <= mod_hi) ? KEY_W'($urandom_range(mod_hi, mod_lo)) : 8'($urandom);
			1: k = kea_pkg::KEY_NONE;
			default: k = KEY_W'($urandom_range(1, 255));
		endcase
		return k;
	endfunction

	// mostly press / text / release sequences among ticks and pops, some noise
	task automatic random_item(input int pop_pct);
		int roll;
		logic [KEY_W-1:0] k;
		roll = $urandom_range(0, 99);
		if (roll < pop_pct) begin
			send(kea_pkg::REQ_POP, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
				{$urandom, $urandom});
		end else if (roll < pop_pct + 35) begin
			send(kea_pkg::REQ_TICK, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
				{$urandom, $urandom});
		end else if (roll < 92) begin
			if (pressed_key == kea_pkg::KEY_NONE) begin
				k = rand_key();
				send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_DOWN, k, 8'($urandom), 1'b0,
					rand_text());
				pressed_key = k;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_TEXT, 8'($urandom),
						8'($urandom), 1'b0, rand_text());
					5, 6: begin
						send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_UP, pressed_key, 8'($urandom),
							1'b0, rand_text());
						pressed_key = kea_pkg::KEY_NONE;
					end
					7: send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_OTHER, rand_key(), 8'($urandom),
						1'b0, rand_text());
					default: begin
						k = rand_key();
						send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_DOWN, k, 8'($urandom), 1'b0,
							rand_text());
						pressed_key = k;
					end
				endcase
			end
		end else begin
			send(2'($urandom), 2'($urandom), rand_key(), 8'($urandom), 1'($urandom),
				{$urandom, $urandom});
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = kea_pkg::REG_DELAY;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = kea_pkg::REQ_POP;
		ev_kind = kea_pkg::KIND_DOWN;
		ev_key = '0;
		ev_modifiers = '0;
		ev_repeat = 1'b0;
		ev_text = '0;
		pressed_key = kea_pkg::KEY_NONE;
		mod_lo = kea_pkg::MOD_FIRST_RST;
		mod_hi = kea_pkg::MOD_LAST_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: pop of an empty queue, a press too short to repeat
		send(kea_pkg::REQ_POP, kea_pkg::KIND_DOWN, 8'h00, 8'h00, 1'b0, '0);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_DOWN, 8'h2c, 8'h02, 1'b0, 64'h20);
		send(kea_pkg::REQ_TICK, kea_pkg::KIND_DOWN, 8'h00, 8'h00, 1'b0, '0);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_UP, 8'h2c, 8'h02, 1'b0, '0);
		drain();

		// directed: short delay and interval so repeats show up quickly
		set_regs(16'd2, 16'd1, 8'd224, 8'd231);
		send(REQ_UNUSED, kea_pkg::KIND_OTHER, 8'hff, 8'hff, 1'b1, '1);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_DOWN, 8'hff, 8'hff, 1'b0, '1);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_TEXT, 8'h00, 8'h01, 1'b0,
			64'h0000_0000_0063_6261);
		// zero byte in the middle cuts the held text
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_TEXT, 8'h10, 8'h80, 1'b0,
			64'h4142_4300_4445_4647);
		send(kea_pkg::REQ_TICK, kea_pkg::KIND_DOWN, 8'h00, 8'h00, 1'b0, '0);
		send(kea_pkg::REQ_TICK, kea_pkg::KIND_DOWN, 8'h00, 8'h00, 1'b0, '0);
		send(kea_pkg::REQ_TICK, kea_pkg::KIND_DOWN, 8'h00, 8'h00, 1'b0, '0);
		// platform repeat is dropped
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_DOWN, 8'h33, 8'h00, 1'b1, 64'h41);
		// modifier range edges do not take over the held key
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_DOWN, 8'd224, 8'h01, 1'b0, '0);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_DOWN, 8'd231, 8'h80, 1'b0, '0);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_OTHER, 8'hff, 8'h00, 1'b0, 64'h7a);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_UP, 8'hfe, 8'h00, 1'b0, '0);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_UP, 8'hff, 8'h00, 1'b0, '0);
		send(kea_pkg::REQ_TICK, kea_pkg::KIND_DOWN, 8'h00, 8'h00, 1'b0, '0);
		// unknown key arms the countdown but holds nothing
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_DOWN, kea_pkg::KEY_NONE, 8'h00, 1'b0, '0);
		send(kea_pkg::REQ_TICK, kea_pkg::KIND_DOWN, 8'h00, 8'h00, 1'b0, '0);
		send(kea_pkg::REQ_SUBMIT, kea_pkg::KIND_TEXT, 8'h00, 8'h00, 1'b0, 64'h31);
		repeat (4) send(kea_pkg::REQ_POP, kea_pkg::KIND_DOWN, 8'h00, 8'h00, 1'b0, '0);
		drain();

		// random phases over several register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					set_regs(16'd3, 16'd2, 8'd224, 8'd231);
					gaps_on = 1'b1;
					repeat (PHASE_ITEMS) random_item(25);
				end
				1: begin
					// zero delay and interval, empty modifier range, queue overflows
					set_regs(16'd0, 16'd0, 8'd255, 8'd0);
					repeat (PHASE_ITEMS) random_item(12);
				end
				2: begin
					// every key a modifier, longest countdowns
					set_regs(16'hffff, 16'hffff, 8'd0, 8'd255);
					gaps_on = 1'b0;
					repeat (PHASE_ITEMS) random_item(30);
				end
				3: begin
					set_regs(CNT_W'($urandom_range(1, 12)), CNT_W'($urandom_range(1, 6)),
						8'($urandom), 8'($urandom));
					gaps_on = 1'b1;
					repeat (PHASE_ITEMS) random_item(20);
				end
				4: begin
					set_regs(16'd1, 16'hffff, 8'($urandom_range(100, 200)),
						8'($urandom_range(150, 255)));
					repeat (PHASE_ITEMS) random_item(35);
				end
				default: begin
					// closing stretch with no gaps or stalls
					set_regs(16'd5, 16'd3, 8'd224, 8'd231);
					gaps_on = 1'b0;
					repeat (PHASE_ITEMS) random_item(30);
				end
			endcase
			drain();
		end

		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
